// ===== rtl/core/mmfs_pkg.sv =====
`default_nettype none
package mmfs_pkg;

    localparam int IDX_W    = 6;
    localparam int MODE_W   = 2;
    localparam int FC_W     = 7;
    localparam int Q_W      = 17;
    localparam int DIV_STEPS = 17;
    localparam int CNT_W    = 5;

    localparam logic [FC_W-1:0]   FEATURE_COUNT_RESET = 7'd64;
    localparam logic [Q_W-1:0]    ONE_Q16             = 17'h10000;
    localparam logic [CNT_W-1:0]  DIV_LAST            = 5'(DIV_STEPS - 1);

    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_XFORM = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_FIT,
        ST_RANGE,
        ST_NUM,
        ST_CMP,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/min_max_feature_scaler_unit.sv =====
`default_nettype none
// Per-feature min-max scaler.
// Input stream: s_tuser carries the mode (clear, fit, transform), s_tdata the
// feature index and the signed sample. Clear resets all feature statistics in
// the transfer cycle. Fit folds the sample into its feature's min/max and gives
// no output. Transform gives (sample-min)/(max-min) as unsigned Q1.16 with a
// clamped flag and a constant-range flag on the output stream.
// Fit/transform items with an index not below feature_count (cfg channel) are dropped.
// Steps: clear, dropped and unused-mode items finish on accept; fit reads the
// RAM, then updates it. Transform runs from accept to the output register
// through read, range, numerator and bound checks, then restoring division,
// one quotient bit per cycle on the single shared subtractor. The input is
// ready again the cycle after the result is loaded.
// A result waits in the output register while m_tready is low; the next item
// is taken meanwhile, and a further result waits until that register frees.
// Reset: all statistics read as min 2^(VALUE_BITS-1)-1 / max -2^(VALUE_BITS-1),
// feature_count returns to 64, no output pending.
module min_max_feature_scaler_unit
    import mmfs_pkg::*;
#(
    parameter int MAX_FEATURES = 64,
    parameter int VALUE_BITS   = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,

    input  wire logic                                     s_tvalid,
    output logic                                          s_tready,
    // [5:0] feature_index, [6+VALUE_BITS-1:6] sample_value, zero fill above
    input  wire logic [((IDX_W + VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // [1:0] mode
    input  wire logic [MODE_W-1:0]                        s_tuser,

    output logic                                          m_tvalid,
    input  wire logic                                     m_tready,
    // [16:0] normalized_value, zero fill above
    output logic      [((Q_W + 7) / 8) * 8 - 1:0]         m_tdata,
    // [0] clamped_flag, [1] constant_flag
    output logic      [1:0]                               m_tuser,

    input  wire logic                                     cfg_valid,
    output logic                                          cfg_ready,
    input  wire logic [FC_W-1:0]                          cfg_data
);

    localparam int ADDR_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int VB     = VALUE_BITS;
    localparam int AW     = VB + 2;
    localparam int OUT_W  = ((Q_W + 7) / 8) * 8;
    localparam logic signed [VB-1:0] VAL_TOP    = {1'b0, {(VB-1){1'b1}}};
    localparam logic signed [VB-1:0] VAL_BOTTOM = {1'b1, {(VB-1){1'b0}}};

    state_t state_reg, state_next;

    logic [FC_W-1:0]         fcount_reg, fcount_next;
    logic [MAX_FEATURES-1:0] valid_reg, valid_next;
    logic                    is_fit_reg, is_fit_next;
    logic [ADDR_W-1:0]       addr_reg, addr_next;
    logic signed [VB-1:0]    v_reg, v_next;
    logic signed [VB-1:0]    lo_reg, lo_next;
    logic signed [VB-1:0]    hi_reg, hi_next;
    logic [VB-1:0]           range_reg, range_next;
    logic [VB-1:0]           num_reg, num_next;
    logic [VB:0]             rem_reg, rem_next;
    logic [Q_W-1:0]          q_reg, q_next;
    logic                    clamp_reg, clamp_next;
    logic                    const_reg, const_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    logic                    mvalid_reg, mvalid_next;
    logic [Q_W-1:0]          mq_reg, mq_next;
    logic                    mclamp_reg, mclamp_next;
    logic                    mconst_reg, mconst_next;

    logic [IDX_W-1:0]        s_idx;
    logic signed [VB-1:0]    s_val;
    logic [31:0]             s_idx_wide;
    logic                    idx_ok;
    logic                    in_xfer;

    logic [AW-1:0]           alu_a, alu_b, alu_diff;
    logic                    alu_neg, alu_zero;

    logic                    ram_we;
    logic [2*VB-1:0]         ram_wdata, ram_rdata;
    logic signed [VB-1:0]    fit_lo, fit_hi;
    logic [VB-1:0]           keep_rem;

    assign s_idx      = s_tdata[IDX_W-1:0];
    assign s_val      = s_tdata[IDX_W+VB-1:IDX_W];
    assign s_idx_wide = 32'(s_idx);
    assign idx_ok     = ({1'b0, s_idx} < fcount_reg) && (s_idx_wide < 32'(MAX_FEATURES));
    assign s_tready   = (state_reg == ST_IDLE);
    assign in_xfer    = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = OUT_W'(mq_reg);
    assign m_tuser  = {mconst_reg, mclamp_reg};

    assign fit_lo    = (v_reg < lo_reg) ? v_reg : lo_reg;
    assign fit_hi    = (v_reg > hi_reg) ? v_reg : hi_reg;
    assign ram_we    = (state_reg == ST_FIT);
    assign ram_wdata = {fit_hi, fit_lo};

    mmfs_ram #(
        .WIDTH (2 * VB),
        .DEPTH (MAX_FEATURES)
    ) u_stats (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (addr_reg),
        .wr_data (ram_wdata),
        .rd_en   (in_xfer),
        .rd_addr (s_idx_wide[ADDR_W-1:0]),
        .rd_data (ram_rdata)
    );

    mmfs_sub #(
        .W (AW)
    ) u_sub (
        .op_a (alu_a),
        .op_b (alu_b),
        .diff (alu_diff),
        .neg  (alu_neg),
        .zero (alu_zero)
    );

    always_comb
    begin
        unique case (state_reg)
            ST_RANGE:
            begin
                alu_a = {{2{hi_reg[VB-1]}}, hi_reg};
                alu_b = {{2{lo_reg[VB-1]}}, lo_reg};
            end
            ST_NUM:
            begin
                alu_a = {{2{v_reg[VB-1]}}, v_reg};
                alu_b = {{2{lo_reg[VB-1]}}, lo_reg};
            end
            ST_CMP:
            begin
                alu_a = {2'b00, range_reg};
                alu_b = {2'b00, num_reg};
            end
            ST_DIV:
            begin
                alu_a = {1'b0, rem_reg};
                alu_b = {2'b00, range_reg};
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    // remainder after the trial subtract always stays below range
    assign keep_rem = alu_neg ? rem_reg[VB-1:0] : alu_diff[VB-1:0];

    always_comb
    begin
        state_next  = state_reg;
        fcount_next = fcount_reg;
        valid_next  = valid_reg;
        is_fit_next = is_fit_reg;
        addr_next   = addr_reg;
        v_next      = v_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        range_next  = range_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        clamp_next  = clamp_reg;
        const_next  = const_reg;
        cnt_next    = cnt_reg;
        mvalid_next = mvalid_reg;
        mq_next     = mq_reg;
        mclamp_next = mclamp_reg;
        mconst_next = mconst_reg;

        if (cfg_valid && cfg_ready)
        begin
            fcount_next = cfg_data;
        end

        if (mvalid_reg && m_tready)
        begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    addr_next   = s_idx_wide[ADDR_W-1:0];
                    v_next      = s_val;
                    is_fit_next = (s_tuser == MODE_FIT);
                    unique case (s_tuser)
                        MODE_CLEAR:
                        begin
                            valid_next = '0;
                        end
                        MODE_FIT, MODE_XFORM:
                        begin
                            if (idx_ok)
                            begin
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (valid_reg[addr_reg])
                begin
                    lo_next = ram_rdata[VB-1:0];
                    hi_next = ram_rdata[2*VB-1:VB];
                end
                else
                begin
                    lo_next = VAL_TOP;
                    hi_next = VAL_BOTTOM;
                end
                state_next = is_fit_reg ? ST_FIT : ST_RANGE;
            end
            ST_FIT:
            begin
                valid_next[addr_reg] = 1'b1;
                state_next           = ST_IDLE;
            end
            ST_RANGE:
            begin
                range_next = alu_diff[VB-1:0];
                q_next     = '0;
                clamp_next = 1'b0;
                const_next = 1'b0;
                if (alu_neg || alu_zero)
                begin
                    const_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_NUM;
                end
            end
            ST_NUM:
            begin
                num_next = alu_diff[VB-1:0];
                if (alu_neg)
                begin
                    clamp_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                rem_next = {1'b0, num_reg};
                cnt_next = '0;
                if (alu_neg)
                begin
                    q_next     = ONE_Q16;
                    clamp_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                q_next   = {q_reg[Q_W-2:0], ~alu_neg};
                rem_next = {keep_rem, 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mq_next     = q_reg;
                    mclamp_next = clamp_reg;
                    mconst_next = const_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fcount_reg <= FEATURE_COUNT_RESET;
            valid_reg  <= '0;
            mvalid_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            fcount_reg <= fcount_next;
            valid_reg  <= valid_next;
            mvalid_reg <= mvalid_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_fit_reg <= is_fit_next;
        addr_reg   <= addr_next;
        v_reg      <= v_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        range_reg  <= range_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        clamp_reg  <= clamp_next;
        const_reg  <= const_next;
        mq_reg     <= mq_next;
        mclamp_reg <= mclamp_next;
        mconst_reg <= mconst_next;
    end

    a_const_zero: assert property (@(posedge clk) disable iff (!rst_n)
        mvalid_reg && mconst_reg |-> (mq_reg == '0) && !mclamp_reg)
        else $error("constant-range result not zero");

    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mvalid_reg |-> (mq_reg <= ONE_Q16))
        else $error("normalized value above 1.0");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> cnt_reg <= DIV_LAST)
        else $error("divider step count overrun");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV && cnt_reg != '0 |-> rem_reg < {range_reg, 1'b0})
        else $error("divider remainder out of range");

    a_busy_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE && s_tvalid && !idx_ok |=> state_reg == ST_IDLE)
        else $error("dropped item started a sequence");

endmodule
`default_nettype wire

// ===== rtl/core/mmfs_ram.sv =====
`default_nettype none
module mmfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                                     clk,
    input  wire logic                                     wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                         wr_data,
    input  wire logic                                     rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/mmfs_sub.sv =====
`default_nettype none
module mmfs_sub #(
    parameter int W = 18
) (
    input  wire logic [W-1:0] op_a,
    input  wire logic [W-1:0] op_b,
    output logic      [W-1:0] diff,
    output logic              neg,
    output logic              zero
);

    always_comb
    begin
        diff = op_a - op_b;
        neg  = diff[W-1];
        zero = (diff == '0);
    end

endmodule
`default_nettype wire

// ===== tb/sv/tb_min_max_feature_scaler_unit.sv =====
`default_nettype none
module tb_min_max_feature_scaler_unit;
    import mmfs_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int STUCK_LIMIT    = 3000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES  = 30;

    typedef struct packed {
        logic [Q_W-1:0] value;
        logic           clamped;
        logic           is_const;
    } scaled_t;

    class scaler_scoreboard;
        logic signed [15:0] lo_store[64];
        logic signed [15:0] hi_store[64];
        logic [FC_W-1:0]    feature_count;
        scaled_t            expected_scaled[$];
        int unsigned        errors;
        int unsigned        n_checked;
        int unsigned        n_clamped;
        int unsigned        n_const;

        function new();
            feature_count = FEATURE_COUNT_RESET;
            errors = 0;
            n_checked = 0;
            n_clamped = 0;
            n_const = 0;
            clear_stats();
        endfunction

        function void clear_stats();
            for (int i = 0; i < 64; i++)
            begin
                lo_store[i] = 16'sh7fff;
                hi_store[i] = 16'sh8000;
            end
        endfunction

        function int pending();
            return expected_scaled.size();
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= 50)
                $display("MISMATCH: %s", msg);
        endtask

        function void note_sample(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx,
                                  input logic signed [15:0] val);
            scaled_t r;
            longint  span;
            longint  offset;
            if (mode == MODE_CLEAR)
            begin
                clear_stats();
                return;
            end
            if (mode != MODE_FIT && mode != MODE_XFORM)
                return;
            if ({1'b0, idx} >= feature_count)
                return;
            if (mode == MODE_FIT)
            begin
                if (val < lo_store[idx])
                    lo_store[idx] = val;
                if (val > hi_store[idx])
                    hi_store[idx] = val;
                return;
            end
            span   = longint'(hi_store[idx]) - longint'(lo_store[idx]);
            offset = longint'(val) - longint'(lo_store[idx]);
            r = '0;
            if (span <= 0)
                r.is_const = 1'b1;
            else if (offset < 0)
                r.clamped = 1'b1;
            else if (offset > span)
            begin
                r.value   = ONE_Q16;
                r.clamped = 1'b1;
            end
            else
                r.value = Q_W'((offset << 16) / span);
            expected_scaled.push_back(r);
        endfunction

        task check_scaled(input logic [Q_W-1:0] value, input logic clamped,
                          input logic is_const);
            scaled_t e;
            if (expected_scaled.size() == 0)
            begin
                report($sformatf("unexpected result value=%0d clamped=%0b const=%0b",
                                 value, clamped, is_const));
                return;
            end
            e = expected_scaled.pop_front();
            n_checked++;
            if (e.clamped)
                n_clamped++;
            if (e.is_const)
                n_const++;
            if (value !== e.value)
                report($sformatf("normalized_value got %0d expected %0d", value, e.value));
            if (clamped !== e.clamped)
                report($sformatf("clamped_flag got %0b expected %0b", clamped, e.clamped));
            if (is_const !== e.is_const)
                report($sformatf("constant_flag got %0b expected %0b", is_const, e.is_const));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [23:0]     s_tdata = '0;   // [5:0] feature_index, [21:6] sample_value
    logic [1:0]      s_tuser = '0;   // [1:0] mode

    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [23:0]     m_tdata;        // [16:0] normalized_value
    logic [1:0]      m_tuser;        // [0] clamped_flag, [1] constant_flag

    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [FC_W-1:0] cfg_data = '0;

    logic            rx_hold_req = 1'b0;
    int              rx_hold_left = 0;
    bit              rx_idle_on = 1'b1;
    bit              tx_idle_on = 1'b1;
    int              stuck_cycles = 0;
    int unsigned     n_sent = 0;
    int unsigned     n_cfg = 0;

    scaler_scoreboard sb = new();

    min_max_feature_scaler_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // output side: random stalls, or a long hold-off on request
    always @(posedge clk)
    begin
        if (rx_hold_left != 0)
        begin
            m_tready     <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end
        else if (rx_hold_req)
        begin
            m_tready     <= 1'b0;
            rx_hold_left <= RX_HOLD_CYCLES;
        end
        else
            m_tready <= !(rx_idle_on && $urandom_range(0, 99) < 7);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_scaled(m_tdata[Q_W-1:0], m_tuser[0], m_tuser[1]);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else if (stuck_cycles == STUCK_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", STUCK_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    task automatic send_sample(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx,
                               input logic signed [15:0] val);
        int gap;
        gap = (tx_idle_on && $urandom_range(0, 99) < 7) ? int'($urandom_range(1, 24)) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {2'b00, val, idx};
        do @(posedge clk); while (!s_tready);
        sb.note_sample(mode, idx, val);
        n_sent++;
    endtask

    task automatic wait_for_results();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_feature_count(input logic [FC_W-1:0] count);
        s_tvalid <= 1'b0;
        wait_for_results();
        // a dropped or fit transfer may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.feature_count = count;
        n_cfg++;
    endtask

    task automatic send_random_item();
        logic [MODE_W-1:0]  mode;
        logic [IDX_W-1:0]   idx;
        logic signed [15:0] val;
        int                 pick;
        int                 span;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            mode = MODE_CLEAR;
        else if (pick < 4)
            mode = MODE_UNUSED;
        else if (pick < 45)
            mode = MODE_FIT;
        else
            mode = MODE_XFORM;
        span = (sb.feature_count > 64) ? 64 : int'(sb.feature_count);
        if (span == 0 || $urandom_range(0, 9) == 0)
            idx = IDX_W'($urandom_range(0, 63));
        else
            idx = IDX_W'($urandom_range(0, span - 1));
        case ($urandom_range(0, 9))
            0:       val = 16'sh8000;
            1:       val = 16'sh7fff;
            2, 3:    val = 16'(int'($urandom_range(0, 64)) - 32);
            default: val = 16'($urandom);
        endcase
        send_sample(mode, idx, val);
    endtask

    task automatic run_random(input int count);
        repeat (count) send_random_item();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_sample(MODE_XFORM, 6'd0, 16'sd0);        // never fitted
        send_sample(MODE_FIT, 6'd0, 16'sh8000);
        send_sample(MODE_FIT, 6'd0, 16'sh7fff);
        send_sample(MODE_XFORM, 6'd0, 16'sh8000);
        send_sample(MODE_XFORM, 6'd0, 16'sh7fff);
        send_sample(MODE_XFORM, 6'd0, 16'sd1);
        send_sample(MODE_FIT, 6'd63, 16'sd5);
        send_sample(MODE_XFORM, 6'd63, 16'sd5);       // zero range
        send_sample(MODE_FIT, 6'd5, 16'sd100);
        send_sample(MODE_FIT, 6'd5, 16'sd200);
        send_sample(MODE_XFORM, 6'd5, 16'sd50);       // below range
        send_sample(MODE_XFORM, 6'd5, 16'sd250);      // above range
        send_sample(MODE_XFORM, 6'd5, 16'sd199);
        send_sample(MODE_UNUSED, 6'd5, 16'sd7);
        send_sample(MODE_CLEAR, 6'd63, 16'shffff);
        send_sample(MODE_XFORM, 6'd5, 16'sd150);
        write_feature_count(7'd4);
        send_sample(MODE_FIT, 6'd4, 16'sd10);         // out of use
        send_sample(MODE_XFORM, 6'd4, 16'sd10);
        send_sample(MODE_FIT, 6'd3, 16'shffff);
        send_sample(MODE_FIT, 6'd3, 16'sd2);
        send_sample(MODE_XFORM, 6'd3, 16'sd0);
        write_feature_count(7'd0);
        send_sample(MODE_FIT, 6'd0, 16'sd9);
        send_sample(MODE_XFORM, 6'd0, 16'sd9);
        send_sample(MODE_CLEAR, 6'd0, 16'sd0);

        // random
        write_feature_count(7'd64);
        run_random(60);
        s_tvalid    <= 1'b0;
        rx_hold_req <= 1'b1;
        @(posedge clk);
        rx_hold_req <= 1'b0;
        repeat (30) send_sample(MODE_XFORM, IDX_W'($urandom_range(0, 63)), 16'($urandom));
        run_random(160);
        write_feature_count(FC_W'($urandom_range(2, 63)));
        run_random(120);
        write_feature_count(7'd1);
        run_random(80);
        write_feature_count(7'd127);
        run_random(70);
        s_tvalid <= 1'b0;
        wait_for_results();
        run_random(80);
        write_feature_count(7'd0);
        run_random(30);
        write_feature_count(7'd64);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random(110);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        run_random(40);

        s_tvalid <= 1'b0;
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("sent %0d transfers over %0d feature_count settings (0, 1, 4, 64, 127, random)",
                 n_sent, n_cfg);
        $display("checked %0d scaled results: %0d clamped, %0d constant range",
                 sb.n_checked, sb.n_clamped, sb.n_const);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire
